// ===== sv/lpr_pkg.sv =====
// Shared types and constants for the lidar point record decoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package lpr_pkg;

  localparam int QUEUE_DEPTH = 8;

  // Job kinds handed from the front to the back: one per field that completes
  typedef enum logic [4:0] {
    K_NONE, K_X, K_Y, K_Z, K_INTENS, K_L_RET, K_L_CLS, K_L_ANGLE, K_USER,
    K_SOURCE, K_TIME, K_V_RET, K_V_FLAGS, K_V_CLASS, K_V_ANGLE,
    K_RED, K_GREEN, K_BLUE, K_NIR
  } kind_t;

  typedef enum logic [4:0] {
    D_X, D_Y, D_Z, D_INTENSITY, D_RETURN, D_RETURNS, D_SCANDIR, D_EDGE,
    D_CLASS, D_SYNTH, D_KEY, D_WITHHELD, D_OVERLAP, D_CHANNEL, D_ANGLE,
    D_USER, D_SOURCE, D_TIME, D_RED, D_GREEN, D_BLUE, D_NIR, D_END
  } dim_code_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] data;   // last eight bytes, newest in the top byte
    logic        last;   // this byte closes the record
  } task_t;

  typedef struct packed {
    logic [3:0]  layout_flags;
    logic [15:0] record_length;
    logic [47:0] scale_x;
    logic [47:0] scale_y;
    logic [47:0] scale_z;
    logic [63:0] offset_x;
    logic [63:0] offset_y;
    logic [63:0] offset_z;
  } cfg_t;

  // Number of dimension results a job yields (the end result not counted)
  function automatic logic [2:0] kind_dims(kind_t k);
    logic [2:0] n;
    case (k)
      K_NONE:    n = 3'd0;
      K_L_RET:   n = 3'd4;
      K_L_CLS:   n = 3'd5;
      K_V_RET:   n = 3'd2;
      K_V_FLAGS: n = 3'd7;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== sv/lpr_front.sv =====
// Front end: accepts record bytes, tracks position and field assembly,
// classifies each byte into a job. Depends on lpr_pkg.
`default_nettype none
module lpr_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lpr_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_first_byte,
  output logic               in_stall,
  input  wire logic          q_full,
  output logic               q_push,
  output lpr_pkg::task_t     q_task
);
  import lpr_pkg::*;

  logic [15:0] pos_r;
  logic [63:0] asm_r;
  logic [63:0] asm_nxt;
  logic [15:0] p;
  logic [15:0] base_len;
  logic [15:0] rec_len;
  logic [15:0] off_color;
  logic [15:0] off_nir;
  logic        v14;
  logic        is_end;
  logic        accept;
  kind_t       kind;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign v14      = cfg.layout_flags[0];
  assign p        = in_first_byte ? 16'd0 : pos_r;
  assign asm_nxt  = {in_data_byte, asm_r[63:8]};

  always_comb begin
    if (v14) begin
      base_len = 16'd30 + (cfg.layout_flags[2] ? 16'd6 : 16'd0)
                        + (cfg.layout_flags[3] ? 16'd2 : 16'd0);
      off_color = 16'd30;
    end else begin
      base_len = 16'd20 + (cfg.layout_flags[1] ? 16'd8 : 16'd0)
                        + (cfg.layout_flags[2] ? 16'd6 : 16'd0);
      off_color = cfg.layout_flags[1] ? 16'd28 : 16'd20;
    end
    off_nir = off_color + (cfg.layout_flags[2] ? 16'd6 : 16'd0);
    rec_len = (cfg.record_length > base_len) ? cfg.record_length : base_len;
    is_end  = ({1'b0, p} + 17'd1) >= {1'b0, rec_len};
  end

  // Classify the field that this byte completes
  always_comb begin
    kind = K_NONE;
    if (p == 16'd3)       kind = K_X;
    else if (p == 16'd7)  kind = K_Y;
    else if (p == 16'd11) kind = K_Z;
    else if (p == 16'd13) kind = K_INTENS;
    else if (!v14) begin
      if (p == 16'd14)      kind = K_L_RET;
      else if (p == 16'd15) kind = K_L_CLS;
      else if (p == 16'd16) kind = K_L_ANGLE;
      else if (p == 16'd17) kind = K_USER;
      else if (p == 16'd19) kind = K_SOURCE;
      else if (cfg.layout_flags[1] && p == 16'd27) kind = K_TIME;
    end else begin
      if (p == 16'd14)      kind = K_V_RET;
      else if (p == 16'd15) kind = K_V_FLAGS;
      else if (p == 16'd16) kind = K_V_CLASS;
      else if (p == 16'd17) kind = K_USER;
      else if (p == 16'd19) kind = K_V_ANGLE;
      else if (p == 16'd21) kind = K_SOURCE;
      else if (p == 16'd29) kind = K_TIME;
    end
    if (kind == K_NONE && cfg.layout_flags[2]) begin
      if (p == off_color + 16'd1)      kind = K_RED;
      else if (p == off_color + 16'd3) kind = K_GREEN;
      else if (p == off_color + 16'd5) kind = K_BLUE;
    end
    if (kind == K_NONE && v14 && cfg.layout_flags[3] && p == off_nir + 16'd1) begin
      kind = K_NIR;
    end
  end

  assign q_push      = accept && (kind != K_NONE || is_end);
  assign q_task.kind = kind;
  assign q_task.data = asm_nxt;
  assign q_task.last = is_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      asm_r <= '0;
    end else if (accept) begin
      asm_r <= asm_nxt;
      pos_r <= is_end ? 16'd0 : p + 16'd1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lpr_queue.sv =====
// Job queue between the front and back ends.
// Depends on lpr_pkg for the job type and depth.
`default_nettype none
module lpr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lpr_pkg::task_t push_task,
  input  wire logic           pop,
  output lpr_pkg::task_t      head_task,
  output logic                full,
  output logic                empty
);
  import lpr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  task_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  head_r;
  logic [PW-1:0]  tail_r;
  logic [CW-1:0]  count_r;

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_task = mem_r[head_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[tail_r] <= push_task;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push && !full) begin
        tail_r <= (tail_r == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      end
      if (pop && !empty) begin
        head_r <= (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/lpr_back.sv =====
// Back end: expands each job into result words, runs the coordinate
// multiply-add sequence and holds the output register. Depends on lpr_pkg.
`default_nettype none
module lpr_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lpr_pkg::cfg_t  cfg,
  input  wire lpr_pkg::task_t head_task,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_valid,
  output logic [4:0]          out_dimension_code,
  output logic signed [63:0]  out_dimension_value,
  output logic                out_saturated,
  output logic                out_last_of_record,
  input  wire logic           out_stall
);
  import lpr_pkg::*;

  localparam logic [4:0] CLASS_OVERLAP = 5'd12;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_SUM, S_NEG, S_ADD, S_EMIT
  } state_t;

  state_t        state_r;
  kind_t         kind_r;
  logic [63:0]   data_r;
  logic          last_r;
  logic [2:0]    nd_r;
  logic [2:0]    k_r;
  logic [31:0]   mag_r;
  logic          neg_r;
  logic [55:0]   p1_r;
  logic [55:0]   p2_r;
  logic [79:0]   prod_r;
  logic [80:0]   sp_r;
  logic [81:0]   tot_r;
  logic          out_valid_r;
  dim_code_t     out_code_r;
  logic [63:0]   out_value_r;
  logic          out_sat_r;
  logic          out_last_r;

  logic [47:0]   scale_sel;
  logic [63:0]   offset_sel;
  logic [31:0]   raw;
  logic [7:0]    b;
  logic [15:0]   t2;
  logic [4:0]    cls;
  logic          ovl;
  logic          coord_fit;
  logic [63:0]   coord_val;
  logic          is_end_word;
  logic          final_word;
  logic          emit_fire;
  logic          take;
  dim_code_t     dim_code;
  logic [63:0]   dim_val;
  logic          dim_sat;

  always_comb begin
    case (kind_r)
      K_Y:     begin scale_sel = cfg.scale_y; offset_sel = cfg.offset_y; end
      K_Z:     begin scale_sel = cfg.scale_z; offset_sel = cfg.offset_z; end
      default: begin scale_sel = cfg.scale_x; offset_sel = cfg.offset_x; end
    endcase
  end

  assign raw       = head_task.data[63:32];
  assign coord_fit = (&tot_r[81:63]) || !(|tot_r[81:63]);
  assign coord_val = coord_fit ? tot_r[63:0]
                   : (tot_r[81] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF);

  assign is_end_word = (k_r == nd_r);
  assign final_word  = is_end_word || ({1'b0, k_r} + 4'd1 == {1'b0, nd_r} && !last_r);
  assign emit_fire   = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign take        = ((state_r == S_IDLE) || (emit_fire && final_word)) && !q_empty;
  assign q_pop       = take;

  // Select the dimension for word k of the current job
  always_comb begin
    b        = data_r[63:56];
    t2       = data_r[63:48];
    cls      = b[4:0];
    ovl      = (cls == CLASS_OVERLAP);
    dim_code = D_END;
    dim_val  = '0;
    dim_sat  = 1'b0;
    case (kind_r)
      K_X, K_Y, K_Z: begin
        dim_code = (kind_r == K_X) ? D_X : ((kind_r == K_Y) ? D_Y : D_Z);
        dim_val  = coord_val;
        dim_sat  = !coord_fit;
      end
      K_INTENS:  begin dim_code = D_INTENSITY; dim_val = {48'd0, t2}; end
      K_L_RET: begin
        case (k_r)
          3'd0:    begin dim_code = D_RETURN;  dim_val = {61'd0, b[2:0]}; end
          3'd1:    begin dim_code = D_RETURNS; dim_val = {61'd0, b[5:3]}; end
          3'd2:    begin dim_code = D_SCANDIR; dim_val = {63'd0, b[6]}; end
          default: begin dim_code = D_EDGE;    dim_val = {63'd0, b[7]}; end
        endcase
      end
      K_L_CLS: begin
        case (k_r)
          3'd0:    begin dim_code = D_CLASS; dim_val = ovl ? 64'd0 : {59'd0, cls}; end
          3'd1:    begin dim_code = D_SYNTH;    dim_val = {63'd0, b[5]}; end
          3'd2:    begin dim_code = D_KEY;      dim_val = {63'd0, b[6]}; end
          3'd3:    begin dim_code = D_WITHHELD; dim_val = {63'd0, b[7]}; end
          default: begin dim_code = D_OVERLAP;  dim_val = {63'd0, ovl}; end
        endcase
      end
      K_L_ANGLE: begin
        dim_code = D_ANGLE;
        dim_val  = {{56{b[7]}}, b} * 64'd1000;
      end
      K_USER:    begin dim_code = D_USER;   dim_val = {56'd0, b}; end
      K_SOURCE:  begin dim_code = D_SOURCE; dim_val = {48'd0, t2}; end
      K_TIME:    begin dim_code = D_TIME;   dim_val = data_r; end
      K_V_RET: begin
        if (k_r == 3'd0) begin
          dim_code = D_RETURN;  dim_val = {60'd0, b[3:0]};
        end else begin
          dim_code = D_RETURNS; dim_val = {60'd0, b[7:4]};
        end
      end
      K_V_FLAGS: begin
        case (k_r)
          3'd0:    begin dim_code = D_SYNTH;    dim_val = {63'd0, b[0]}; end
          3'd1:    begin dim_code = D_KEY;      dim_val = {63'd0, b[1]}; end
          3'd2:    begin dim_code = D_WITHHELD; dim_val = {63'd0, b[2]}; end
          3'd3:    begin dim_code = D_OVERLAP;  dim_val = {63'd0, b[3]}; end
          3'd4:    begin dim_code = D_CHANNEL;  dim_val = {62'd0, b[5:4]}; end
          3'd5:    begin dim_code = D_SCANDIR;  dim_val = {63'd0, b[6]}; end
          default: begin dim_code = D_EDGE;     dim_val = {63'd0, b[7]}; end
        endcase
      end
      K_V_CLASS: begin dim_code = D_CLASS; dim_val = {56'd0, b}; end
      K_V_ANGLE: begin
        dim_code = D_ANGLE;
        dim_val  = {{48{t2[15]}}, t2} * 64'd6;
      end
      K_RED:     begin dim_code = D_RED;   dim_val = {48'd0, t2}; end
      K_GREEN:   begin dim_code = D_GREEN; dim_val = {48'd0, t2}; end
      K_BLUE:    begin dim_code = D_BLUE;  dim_val = {48'd0, t2}; end
      K_NIR:     begin dim_code = D_NIR;   dim_val = {48'd0, t2}; end
      default:   begin dim_code = D_END;   dim_val = '0; end
    endcase
    if (is_end_word) begin
      dim_code = D_END;
      dim_val  = '0;
      dim_sat  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        state_r <= (head_task.kind == K_X || head_task.kind == K_Y ||
                    head_task.kind == K_Z) ? S_MUL_LO : S_EMIT;
      end else begin
        case (state_r)
          S_MUL_LO: state_r <= S_MUL_HI;
          S_MUL_HI: state_r <= S_SUM;
          S_SUM:    state_r <= S_NEG;
          S_NEG:    state_r <= S_ADD;
          S_ADD:    state_r <= S_EMIT;
          S_EMIT:   if (emit_fire && final_word && q_empty) state_r <= S_IDLE;
          default:  state_r <= S_IDLE;
        endcase
      end
    end
    // Payload: no reset needed
    if (take) begin
      kind_r <= head_task.kind;
      data_r <= head_task.data;
      last_r <= head_task.last;
      nd_r   <= kind_dims(head_task.kind);
      k_r    <= '0;
      neg_r  <= raw[31];
      mag_r  <= raw[31] ? (~raw + 32'd1) : raw;
    end else if (emit_fire) begin
      k_r <= k_r + 3'd1;
    end
    p1_r   <= 56'(mag_r) * 56'(scale_sel[23:0]);
    p2_r   <= 56'(mag_r) * 56'(scale_sel[47:24]);
    prod_r <= {p2_r, 24'd0} + {24'd0, p1_r};
    sp_r   <= neg_r ? (~{1'b0, prod_r} + 81'd1) : {1'b0, prod_r};
    tot_r  <= {sp_r[80], sp_r} + {{18{offset_sel[63]}}, offset_sel};
    if (emit_fire) begin
      out_code_r  <= dim_code;
      out_value_r <= dim_val;
      out_sat_r   <= dim_sat;
      out_last_r  <= is_end_word;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dimension_code  = out_code_r;
  assign out_dimension_value = out_value_r;
  assign out_saturated       = out_sat_r;
  assign out_last_of_record  = out_last_r;

endmodule
`default_nettype wire

// ===== sv/las_point_record_decoder.sv =====
// Top level of the lidar point record decoder: register port, front end,
// job queue and back end. Depends on lpr_pkg, lpr_front, lpr_queue, lpr_back.
//
// The block takes point record bytes, one byte per accepted cycle, and emits
// one result word per decoded dimension in byte order, then an end word on
// the last byte of each record. The front end accepts a byte every cycle as
// long as the job queue (QUEUE_DEPTH jobs) has room; a byte that completes a
// field or closes a record queues one job. The back end delivers up to one
// result word per cycle while the output is not stalled; a coordinate job
// first passes through the back end's multiply-add sequence (two 32x24
// partial products, sum, sign, offset add) before its word leaves. A stream
// of legacy 20-byte records is paced by the back end's word rate and the
// coordinate sequence rather than by byte intake, and output stalls slow it
// further. Registers sit at byte address 8*i, 64 bits wide; write them only
// while the block is idle.
`default_nettype none
module las_point_record_decoder (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  wire logic         in_valid,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_first_byte,
  output logic              in_stall,
  output logic              out_valid,
  output logic [4:0]        out_dimension_code,
  output logic signed [63:0] out_dimension_value,
  output logic              out_saturated,
  output logic              out_last_of_record,
  input  wire logic         out_stall
);
  import lpr_pkg::*;

  typedef enum logic [2:0] {
    R_LAYOUT, R_LENGTH, R_SCALE_X, R_SCALE_Y, R_SCALE_Z,
    R_OFFSET_X, R_OFFSET_Y, R_OFFSET_Z
  } reg_idx_t;

  cfg_t      cfg_r;
  reg_idx_t  reg_idx;
  logic      cfg_write;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  task_t     push_task;
  task_t     head_task;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[5:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Register file: hold each field at its own width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.layout_flags  <= 4'd0;
      cfg_r.record_length <= 16'd20;
      cfg_r.scale_x       <= 48'd1099511627;
      cfg_r.scale_y       <= 48'd1099511627;
      cfg_r.scale_z       <= 48'd1099511627;
      cfg_r.offset_x      <= '0;
      cfg_r.offset_y      <= '0;
      cfg_r.offset_z      <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        R_LAYOUT:   cfg_r.layout_flags  <= pwdata[3:0];
        R_LENGTH:   cfg_r.record_length <= pwdata[15:0];
        R_SCALE_X:  cfg_r.scale_x       <= pwdata[47:0];
        R_SCALE_Y:  cfg_r.scale_y       <= pwdata[47:0];
        R_SCALE_Z:  cfg_r.scale_z       <= pwdata[47:0];
        R_OFFSET_X: cfg_r.offset_x      <= pwdata;
        R_OFFSET_Y: cfg_r.offset_y      <= pwdata;
        R_OFFSET_Z: cfg_r.offset_z      <= pwdata;
        default:    cfg_r.offset_z      <= cfg_r.offset_z;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      R_LAYOUT:   prdata = {60'd0, cfg_r.layout_flags};
      R_LENGTH:   prdata = {48'd0, cfg_r.record_length};
      R_SCALE_X:  prdata = {16'd0, cfg_r.scale_x};
      R_SCALE_Y:  prdata = {16'd0, cfg_r.scale_y};
      R_SCALE_Z:  prdata = {16'd0, cfg_r.scale_z};
      R_OFFSET_X: prdata = cfg_r.offset_x;
      R_OFFSET_Y: prdata = cfg_r.offset_y;
      R_OFFSET_Z: prdata = cfg_r.offset_z;
      default:    prdata = '0;
    endcase
  end

  // Front: track record position, classify bytes into jobs
  lpr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_task        (push_task)
  );

  // Queue: decouple byte intake from result delivery
  lpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_task (push_task),
    .pop       (q_pop),
    .head_task (head_task),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: expand jobs into result words
  lpr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .head_task           (head_task),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_dimension_code  (out_dimension_code),
    .out_dimension_value (out_dimension_value),
    .out_saturated       (out_saturated),
    .out_last_of_record  (out_last_of_record),
    .out_stall           (out_stall)
  );

  // The end word and only the end word carries the record-end flag
  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_record |-> out_dimension_code == D_END)
    else $error("record end flag on a non-end word");

  // Clipping applies to coordinates alone
  a_sat_coord: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_dimension_code == D_X || out_dimension_code == D_Y ||
       out_dimension_code == D_Z))
    else $error("saturated flag on a non-coordinate word");

  // The end word carries a zero value
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dimension_code == D_END |->
      out_dimension_value == 64'sd0 && out_last_of_record)
    else $error("malformed end word");

endmodule
`default_nettype wire

// ===== tb/las_point_record_decoder_tb.sv =====
// Self-checking testbench for las_point_record_decoder: streams point record bytes,
// predicts every decoded dimension word and checks the result stream in order.
// Depends on lpr_pkg and the decoder RTL; needs no files or arguments.
`timescale 1ns / 1ps

module las_point_record_decoder_tb;
  import lpr_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 500;

  // layout_flags bit positions
  localparam int LF_V14   = 0;
  localparam int LF_TIME  = 1;
  localparam int LF_COLOR = 2;
  localparam int LF_NIR   = 3;

  typedef enum int {
    REG_LAYOUT, REG_RECORD_LENGTH, REG_SCALE_X, REG_SCALE_Y, REG_SCALE_Z,
    REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z
  } reg_index_t;

  typedef struct {
    dim_code_t   code;
    logic [63:0] value;
    logic        sat;
    logic        last;
  } dim_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = '0;
  logic        in_first_byte = 1'b0;
  logic        in_stall;

  logic              out_valid;
  logic [4:0]        out_dimension_code;
  logic signed [63:0] out_dimension_value;
  logic              out_saturated;
  logic              out_last_of_record;
  logic              out_stall = 1'b0;

  // Mirror of the register file
  logic [3:0]  cfg_flags = 4'd0;
  logic [15:0] cfg_rec_len = 16'd20;
  logic [47:0] cfg_scale [3] = '{default: 48'd1099511627};
  logic [63:0] cfg_offset [3] = '{default: 64'd0};

  // Decoder state as the predictor sees it
  int unsigned rec_pos = 0;
  logic [63:0] rec_window = '0;   // last eight bytes, newest in the top byte

  dim_word_t dims_due [$];
  dim_word_t due;
  int        mismatches = 0;
  int        cycle_count = 0;

  bit sender_idle = 1'b0;
  bit receiver_idle = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  las_point_record_decoder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_data_byte        (in_data_byte),
    .in_first_byte       (in_first_byte),
    .in_stall            (in_stall),
    .out_valid           (out_valid),
    .out_dimension_code  (out_dimension_code),
    .out_dimension_value (out_dimension_value),
    .out_saturated       (out_saturated),
    .out_last_of_record  (out_last_of_record),
    .out_stall           (out_stall)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("las_point_record_decoder_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic void put_dim(dim_code_t code, logic [63:0] value,
                                  logic sat = 1'b0, logic last = 1'b0);
    dim_word_t w;
    w = '{code, value, sat, last};
    dims_due = {dims_due, w};
  endfunction

  // Record span: base fields of the current layout, or the register if longer
  function automatic int unsigned rec_span();
    int unsigned base;
    if (cfg_flags[LF_V14])
      base = 30 + (cfg_flags[LF_COLOR] ? 6 : 0) + (cfg_flags[LF_NIR] ? 2 : 0);
    else
      base = 20 + (cfg_flags[LF_TIME] ? 8 : 0) + (cfg_flags[LF_COLOR] ? 6 : 0);
    return (cfg_rec_len > base) ? cfg_rec_len : base;
  endfunction

  // raw * scale + offset, exact in 128 bits, clipped to signed Q23.40
  function automatic logic [63:0] coord_q2340(logic [31:0] raw, logic [47:0] scale,
                                              logic [63:0] offset, output logic sat);
    logic signed [127:0] raw_w, scale_w, off_w, sum;
    raw_w   = {{96{raw[31]}}, raw};
    scale_w = {80'd0, scale};
    off_w   = {{64{offset[63]}}, offset};
    sum     = raw_w * scale_w + off_w;
    if ((&sum[127:63]) || !(|sum[127:63])) begin
      sat = 1'b0;
      return sum[63:0];
    end
    sat = 1'b1;
    return sum[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  // Advance the record state by one accepted byte and queue its dimension words
  function automatic void predict_byte(logic [7:0] b, logic first);
    int unsigned span, p, off, axis;
    logic v14, class12, sat;
    logic [63:0] v;
    logic signed [63:0] angle;
    dim_code_t code;
    span = rec_span();
    v14 = cfg_flags[LF_V14];
    if (first)
      rec_pos = 0;
    rec_window = {b, rec_window[63:8]};
    p = rec_pos;
    off = v14 ? 30 : (cfg_flags[LF_TIME] ? 28 : 20);

    if (p == 3 || p == 7 || p == 11) begin
      axis = (p - 3) / 4;
      code = (axis == 0) ? D_X : (axis == 1) ? D_Y : D_Z;
      v = coord_q2340(rec_window[63:32], cfg_scale[axis], cfg_offset[axis], sat);
      put_dim(code, v, sat);
    end else if (p == 13) begin
      put_dim(D_INTENSITY, 64'(rec_window[63:48]));
    end else if (!v14) begin
      case (p)
        14: begin
          put_dim(D_RETURN, 64'(b[2:0]));
          put_dim(D_RETURNS, 64'(b[5:3]));
          put_dim(D_SCANDIR, 64'(b[6]));
          put_dim(D_EDGE, 64'(b[7]));
        end
        15: begin
          // legacy overlap: class 12 is reported as class 0 plus the flag
          class12 = (b[4:0] == 5'd12);
          put_dim(D_CLASS, class12 ? 64'd0 : 64'(b[4:0]));
          put_dim(D_SYNTH, 64'(b[5]));
          put_dim(D_KEY, 64'(b[6]));
          put_dim(D_WITHHELD, 64'(b[7]));
          put_dim(D_OVERLAP, 64'(class12));
        end
        16: begin
          angle = $signed(b) * 1000;
          put_dim(D_ANGLE, angle);
        end
        17: put_dim(D_USER, 64'(b));
        19: put_dim(D_SOURCE, 64'(rec_window[63:48]));
        27: if (cfg_flags[LF_TIME]) put_dim(D_TIME, rec_window);
        default: ;
      endcase
    end else begin
      case (p)
        14: begin
          put_dim(D_RETURN, 64'(b[3:0]));
          put_dim(D_RETURNS, 64'(b[7:4]));
        end
        15: begin
          put_dim(D_SYNTH, 64'(b[0]));
          put_dim(D_KEY, 64'(b[1]));
          put_dim(D_WITHHELD, 64'(b[2]));
          put_dim(D_OVERLAP, 64'(b[3]));
          put_dim(D_CHANNEL, 64'(b[5:4]));
          put_dim(D_SCANDIR, 64'(b[6]));
          put_dim(D_EDGE, 64'(b[7]));
        end
        16: put_dim(D_CLASS, 64'(b));
        17: put_dim(D_USER, 64'(b));
        19: begin
          angle = $signed(rec_window[63:48]) * 6;
          put_dim(D_ANGLE, angle);
        end
        21: put_dim(D_SOURCE, 64'(rec_window[63:48]));
        29: put_dim(D_TIME, rec_window);
        default: ;
      endcase
    end

    if (cfg_flags[LF_COLOR]) begin
      if (p == off + 1) put_dim(D_RED, 64'(rec_window[63:48]));
      if (p == off + 3) put_dim(D_GREEN, 64'(rec_window[63:48]));
      if (p == off + 5) put_dim(D_BLUE, 64'(rec_window[63:48]));
      off += 6;
    end
    if (v14 && cfg_flags[LF_NIR] && p == off + 1)
      put_dim(D_NIR, 64'(rec_window[63:48]));

    if (p + 1 >= span) begin
      put_dim(D_END, 64'd0, 1'b0, 1'b1);
      rec_pos = 0;
    end else begin
      rec_pos = p + 1;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result checking: compare every accepted word with the oldest one due
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (dims_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: code %0d value %h sat %b last %b",
                   out_dimension_code, out_dimension_value, out_saturated,
                   out_last_of_record);
      end else begin
        due = dims_due.pop_front();
        if (out_dimension_code !== due.code || out_dimension_value !== due.value ||
            out_saturated !== due.sat || out_last_of_record !== due.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %s %h sat %b last %b, got %0d %h sat %b last %b",
                     due.code.name(), due.value, due.sat, due.last, out_dimension_code,
                     out_dimension_value, out_saturated, out_last_of_record);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: long holds on request, otherwise random stalls when enabled
  // ---------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (receiver_idle)
        stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------
  // Sender and register port
  // ---------------------------------------------------------------------

  // Offer one word, hold it until accepted, then predict from it.
  // Valid stays high on return so back-to-back words leave no bubble.
  task automatic send_byte(logic [7:0] b, logic first);
    int gap;
    gap = sender_idle ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    in_first_byte = first;
    do @(posedge clk); while (in_stall);
    predict_byte(b, first);
  endtask

  // Drop valid, drain every word due, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (dims_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [63:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 6'(idx * 8);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LAYOUT:        cfg_flags = value[3:0];
      REG_RECORD_LENGTH: cfg_rec_len = value[15:0];
      REG_SCALE_X:       cfg_scale[0] = value[47:0];
      REG_SCALE_Y:       cfg_scale[1] = value[47:0];
      REG_SCALE_Z:       cfg_scale[2] = value[47:0];
      REG_OFFSET_X:      cfg_offset[0] = value;
      REG_OFFSET_Y:      cfg_offset[1] = value;
      REG_OFFSET_Z:      cfg_offset[2] = value;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_block(logic [3:0] flags, logic [15:0] len,
                               logic [47:0] sx, logic [47:0] sy, logic [47:0] sz,
                               logic [63:0] ox, logic [63:0] oy, logic [63:0] oz);
    write_reg(REG_LAYOUT, flags);
    write_reg(REG_RECORD_LENGTH, len);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_SCALE_Z, sz);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
  endtask

  function automatic logic [47:0] rand_scale();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return 48'(r[31:0] >> $urandom_range(0, 31));
      1: return '1;
      default: return r[47:0];
    endcase
  endfunction

  function automatic logic [63:0] rand_offset();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return {{32{r[31]}}, r[31:0]};
      1: return {r[0], {63{~r[0]}}};
      default: return r;
    endcase
  endfunction

  // Mostly whole records with random content; some cut short and restarted,
  // some stray words with random record-start flags
  task automatic send_random_records(int unsigned nbytes);
    int unsigned sent, n, span, pick;
    bit lead;
    sent = 0;
    while (sent < nbytes) begin
      span = rec_span();
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // restart explicitly if out of step, else at random; cut very long records to 20 to 48 bytes
        lead = (rec_pos != 0) || ($urandom_range(0, 1) == 1);
        n = (span > 48) ? $urandom_range(20, 48) : span;
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(0, 255)), lead && i == 0);
      end else if (pick < 90) begin
        n = $urandom_range(1, span - 1);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(0, 255)), i == 0);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      sent += n;
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Legacy record at reset settings: extreme counts, all flag bits set,
  // class 12 folded into overlap, most negative scan angle
  task automatic test_reset_record();
    logic [7:0] rec [20] = '{
      8'h00, 8'h00, 8'h00, 8'h80,  8'hFF, 8'hFF, 8'hFF, 8'h7F,
      8'h00, 8'h00, 8'h00, 8'h00,  8'hFF, 8'hFF, 8'hFF, 8'hEC,
      8'h80, 8'h00, 8'hFF, 8'hFF};
    for (int i = 0; i < 20; i++)
      send_byte(rec[i], i == 0);
    wait_idle();
  endtask

  // Full-scale coordinates against extreme offsets: clip high, clip low, exact max.
  // Leave the record open so the next test restarts it.
  task automatic test_saturation();
    logic [7:0] rec [12] = '{
      8'hFF, 8'hFF, 8'hFF, 8'h7F,  8'h00, 8'h00, 8'h00, 8'h80,
      8'h00, 8'h00, 8'h00, 8'h00};
    program_block(4'h0, 16'd0, '1, '1, '1,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h7FFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 12; i++)
      send_byte(rec[i], i == 0);
    wait_idle();
  endtask

  // Forced restart of the open record, then shrink the record mid-way:
  // the next word lies past the new end and must close the record
  task automatic test_length_shrink();
    write_reg(REG_LAYOUT, 64'h2);
    write_reg(REG_RECORD_LENGTH, 64'd20);
    for (int i = 0; i < 22; i++)
      send_byte(8'($urandom_range(0, 255)), i == 0);
    wait_idle();
    write_reg(REG_LAYOUT, 64'h0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering: the job queue
  // fills and the input must stall without losing or reordering words
  task automatic test_backpressure();
    program_block(4'h5, 16'd36, '0, '0, '0,
                  64'h8000_0000_0000_0000, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    sender_idle = 1'b0;
    receiver_idle = 1'b1;
    hold_left = HOLD_CYCLES;
    send_random_records(48);
    wait_idle();
  endtask

  task automatic test_random_phase(logic [3:0] flags, logic [15:0] len, bit idle,
                                   int unsigned nbytes);
    program_block(flags, len, rand_scale(), rand_scale(), rand_scale(),
                  rand_offset(), rand_offset(), rand_offset());
    sender_idle = idle;
    receiver_idle = idle;
    send_random_records(nbytes);
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    test_reset_record();
    test_saturation();
    test_length_shrink();
    test_backpressure();

    // 1.4 with color and infrared, time bit set but meaningless there
    test_random_phase(4'hF, 16'($urandom_range(0, 48)), 1'b1, 48);
    // legacy with time and color
    test_random_phase(4'h6, 16'($urandom_range(0, 48)), 1'b1, 48);
    // 1.4 with infrared only, no idling on either side
    test_random_phase(4'hB, 16'($urandom_range(0, 48)), 1'b0, 48);
    // legacy with the infrared bit ignored, longest record length
    test_random_phase(4'h8, 16'hFFFF, 1'b1, 48);
    test_random_phase(4'($urandom_range(0, 15)), 16'($urandom_range(0, 48)), 1'b1, 48);
    test_random_phase(4'($urandom_range(0, 15)), 16'($urandom_range(0, 48)), 1'b1, 48);

    if (mismatches == 0 && dims_due.size() == 0) begin
      $display("las_point_record_decoder_tb: PASS");
    end else begin
      $display("las_point_record_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== las_point_record_decoder.f =====
sv/lpr_pkg.sv
sv/lpr_front.sv
sv/lpr_queue.sv
sv/lpr_back.sv
sv/las_point_record_decoder.sv
tb/las_point_record_decoder_tb.sv
